### rtl/core/u16u8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared types, code-range constants and the byte selection function used by
// the front end, the item queue and the byte serializer.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int UnitW = 16;
  localparam int CpW   = 21;
  localparam int ByteW = 8;

  // Surrogate ranges of a UTF-16 code unit.
  localparam logic [UnitW-1:0] HiSurLo = 16'hd800;
  localparam logic [UnitW-1:0] HiSurHi = 16'hdbff;
  localparam logic [UnitW-1:0] LoSurLo = 16'hdc00;
  localparam logic [UnitW-1:0] LoSurHi = 16'hdfff;
  localparam logic [CpW-1:0]   SuppBase = 21'h10000;

  // Upper bounds of the one, two and three byte encodings.
  localparam logic [CpW-1:0] Max1B = 21'h7f;
  localparam logic [CpW-1:0] Max2B = 21'h7ff;
  localparam logic [CpW-1:0] Max3B = 21'hffff;

  // Lead and continuation byte prefixes.
  localparam logic [ByteW-1:0] Lead2 = 8'hc0;
  localparam logic [ByteW-1:0] Lead3 = 8'he0;
  localparam logic [ByteW-1:0] Lead4 = 8'hf0;
  localparam logic [ByteW-1:0] Cont  = 8'h80;

  // Encoded length minus one.
  typedef enum logic [1:0] {
    LEN_1 = 2'd0,
    LEN_2 = 2'd1,
    LEN_3 = 2'd2,
    LEN_4 = 2'd3
  } len_t;

  // One classified code point waiting to be serialized.
  typedef struct packed {
    logic [CpW-1:0] cp;
    len_t           len;
  } item_t;

  // Queue status seen by both neighbors.
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  // Byte number idx (0 = lead byte) of the UTF-8 form of cp.
  function automatic logic [ByteW-1:0] utf8_byte_sel(input logic [CpW-1:0] cp,
                                                    input len_t len,
                                                    input logic [1:0] idx);
    logic [ByteW-1:0] res;
    logic [1:0]       rem;
    rem = 2'(len) - idx;
    if (idx == 2'd0) begin
      unique case (len)
        LEN_1:   res = {1'b0, cp[6:0]};
        LEN_2:   res = Lead2 | {3'b000, cp[10:6]};
        LEN_3:   res = Lead3 | {4'b0000, cp[15:12]};
        default: res = Lead4 | {5'b00000, cp[20:18]};
      endcase
    end else begin
      unique case (rem)
        2'd0:    res = Cont | {2'b00, cp[5:0]};
        2'd1:    res = Cont | {2'b00, cp[11:6]};
        default: res = Cont | {2'b00, cp[17:12]};
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/utf16_to_utf8_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Converts a stream of UTF-16 code units into a stream of UTF-8 bytes.
//
// Channel  Dir  tdata            tuser           tlast
// in_      in   [15:0] unit      [0] str start   -
// out_     out  [7:0] byte       -               last byte of unit
//
// Each unit yields as many bytes as its code point needs (1 to 4, none for a
// high surrogate), emitted by the byte serializer.
// Input is taken every cycle while the two-entry item queue has room.
// Reset clears the pending surrogate, the queue pointers and count, and the output valid flag.
// Output stalls back up through the queue to in_tready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
  import u16u8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [UnitW-1:0] in_tdata,   // [15:0] code_unit
  input  wire logic             in_tuser,   // [0] string_start
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [ByteW-1:0]      out_tdata,  // [7:0] utf8_byte
  output logic                  out_tlast   // last_byte
);

  q_status_t q_status;
  item_t     push_item, head;
  logic      push, pop;

  // Front end: surrogate pairing and classification.
  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Item queue between the two halves.
  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  // Back end: byte serialization.
  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### rtl/core/u16u8_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-16 front end
// Accepts code units, pairs surrogates, and pushes each resulting code point
// with its encoded length into the item queue.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [UnitW-1:0] in_tdata,   // [15:0] code_unit
  input  wire logic             in_tuser,   // [0] string_start
  input  wire q_status_t        q_status,
  output logic                  push,
  output item_t                 push_item
);

  logic [CpW-1:0] pending_r, pending_nxt;
  logic [CpW-1:0] base;
  logic [CpW-1:0] cp;
  logic           is_high, is_low, accept;

  // Accept while the queue has room.
  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;

  // Classify the unit and build its code point.
  always_comb begin
    is_high = (in_tdata >= HiSurLo) && (in_tdata <= HiSurHi);
    is_low  = (in_tdata >= LoSurLo) && (in_tdata <= LoSurHi);
    base    = in_tuser ? '0 : pending_r;
    if (is_low) begin
      cp = base | {11'd0, in_tdata[9:0]};
    end else begin
      cp = {5'd0, in_tdata};
    end
    if (cp <= Max1B) begin
      push_item.len = LEN_1;
    end else if (cp <= Max2B) begin
      push_item.len = LEN_2;
    end else if (cp <= Max3B) begin
      push_item.len = LEN_3;
    end else begin
      push_item.len = LEN_4;
    end
    push_item.cp = cp;
    push         = accept && !is_high;
    pending_nxt  = pending_r;
    if (accept) begin
      if (is_high) begin
        pending_nxt = SuppBase + {1'b0, in_tdata[9:0], 10'd0};
      end else begin
        pending_nxt = '0;
      end
    end
  end

  // Pending surrogate register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/u16u8_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue of classified code points between front end and serializer.
// ----------------------------------------------------------------------------
module u16u8_queue
  import u16u8_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_status_t  q_status
);

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign head           = mem_r[rd_ptr_r];
  assign q_status.valid = (count_r != 2'd0);
  assign q_status.full  = (count_r == 2'd2);

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && count_r == 2'd2 && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

### rtl/core/u16u8_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte serializer
// Emits the UTF-8 bytes of the queue head one per cycle while out_tready allows,
// into an output register, and retires the item with its last byte.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire item_t      head,
  input  wire q_status_t  q_status,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [ByteW-1:0] out_tdata,  // [7:0] utf8_byte
  output logic            out_tlast    // last_byte
);

  logic [1:0]       idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] data_r, data_nxt;
  logic             last_r, last_nxt;
  logic             load, is_last;

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

  // Load the next byte whenever the output register is free or draining.
  always_comb begin
    load      = q_status.valid && (!valid_r || out_tready);
    is_last   = (idx_r == 2'(head.len));
    pop       = load && is_last;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_tready;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = utf8_byte_sel(head.cp, head.len, idx_r);
      last_nxt  = is_last;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  // Byte index and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.valid |-> idx_r <= 2'(head.len)) else $error("byte index past item");
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tlast)) else $error("retired item without last byte");
  a_idx_reset: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0) else $error("byte index not cleared after retire");

endmodule
`default_nettype wire
